@@ rtl/ft_gravity_compensation_core_defines.svh @@
// assertion macros shared by the ft gravity compensation checker
// no dependencies; expects clk_i and rst_ni in the scope of use
`ifndef FT_GRAVITY_COMPENSATION_CORE_DEFINES_SVH
`define FT_GRAVITY_COMPENSATION_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FTGC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ft gravity compensation check failed");

// next-cycle implication, disabled during reset
`define FTGC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ft gravity compensation check failed");

`endif

@@ rtl/ftgc_pkg.sv @@
// shared widths, vector types, register codes and saturation helper
// no dependencies
package ftgc_pkg;

  localparam int RotW  = 18;  // rotation entries, Q2.16
  localparam int CompW = 18;  // one packed config component
  localparam int CfgW  = 3 * CompW;
  localparam int GW    = 22;  // rotated gravity, unsaturated
  localparam int CW    = 25;  // cross product, unsaturated
  localparam int FsumW = 24;  // negated force sum
  localparam int TsumW = 27;  // negated torque sum
  localparam int OutW  = 20;
  localparam int FracW = 16;
  localparam int CfgIdxW = 3;

  typedef logic [8:0][RotW-1:0]  mat_t;
  typedef logic [2:0][CompW-1:0] vec18_t;
  typedef logic [2:0][GW-1:0]    vecg_t;
  typedef logic [2:0][CW-1:0]    vecc_t;
  typedef logic [2:0][FsumW-1:0] vecf_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GRAVITY     = 3'd0,
    REG_FORCE_BIAS  = 3'd1,
    REG_MASS_CENTER = 3'd2,
    REG_TORQUE_BIAS = 3'd3
  } cfg_reg_e;

  // clamp to the signed output range
  function automatic logic [OutW-1:0] sat_out(input logic signed [TsumW-1:0] x);
    logic [OutW-1:0] r;
    if (x > 27'sd524287) begin
      r = 20'h7FFFF;
    end else if (x < -27'sd524288) begin
      r = 20'h80000;
    end else begin
      r = x[OutW-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/ftgc_rotate.sv @@
// rotates the base-frame gravity vector into the sensor frame, two stages
// depends on ftgc_pkg
module ftgc_rotate import ftgc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  mat_t  rot_i,
  input  vec18_t grav_i,
  output logic  valid_o,
  input  logic  ready_i,
  output vecg_t grav_s_o
);

  logic [2:0][2:0][2*RotW-1:0] prod_d, prod_q;
  vecg_t g_d, g_q;
  logic v1_q, v2_q;
  logic rdy1, rdy2;

  // stage advance
  assign rdy2    = !v2_q || ready_i;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  // nine products R[j][i] * L[j]
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[i][j] = $signed(rot_i[j*3+i]) * $signed(grav_i[j]);
      end
    end
  end

  // column sums with round half up
  always_comb begin
    logic signed [2*RotW+1:0] acc;
    for (int i = 0; i < 3; i++) begin
      acc = $signed(prod_q[i][0]) + $signed(prod_q[i][1]) + $signed(prod_q[i][2])
            + 38'sd32768;
      g_d[i] = acc[2*RotW+1:FracW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) prod_q <= prod_d;
    if (rdy2 && v1_q) g_q <= g_d;
  end

  assign valid_o  = v2_q;
  assign grav_s_o = g_q;

endmodule

@@ rtl/ftgc_cross.sv @@
// mass centre cross rotated gravity and negated force sum, two stages
// depends on ftgc_pkg
module ftgc_cross import ftgc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  vecg_t  grav_s_i,
  input  vec18_t mass_i,
  input  vec18_t fbias_i,
  output logic   valid_o,
  input  logic   ready_i,
  output vecc_t  cross_o,
  output vecf_t  fsum_o
);

  localparam int PW = CompW + GW;

  logic [2:0][PW-1:0] pa_d, pa_q, pb_d, pb_q;
  vecf_t fs_d, fs3_q, fs4_q;
  vecc_t c_d, c_q;
  logic v3_q, v4_q;
  logic rdy3, rdy4;

  assign rdy4    = !v4_q || ready_i;
  assign rdy3    = !v3_q || rdy4;
  assign ready_o = rdy3;

  // products for c = r x g, component i = r[a]*g[b] - r[b]*g[a]
  always_comb begin
    pa_d[0] = $signed(mass_i[1]) * $signed(grav_s_i[2]);
    pb_d[0] = $signed(mass_i[2]) * $signed(grav_s_i[1]);
    pa_d[1] = $signed(mass_i[2]) * $signed(grav_s_i[0]);
    pb_d[1] = $signed(mass_i[0]) * $signed(grav_s_i[2]);
    pa_d[2] = $signed(mass_i[0]) * $signed(grav_s_i[1]);
    pb_d[2] = $signed(mass_i[1]) * $signed(grav_s_i[0]);
    for (int i = 0; i < 3; i++) begin
      fs_d[i] = -($signed(fbias_i[i]) + $signed(grav_s_i[i]));
    end
  end

  // difference with round half up
  always_comb begin
    logic signed [PW:0] diff;
    for (int i = 0; i < 3; i++) begin
      diff   = $signed(pa_q[i]) - $signed(pb_q[i]) + 41'sd32768;
      c_d[i] = diff[PW:FracW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy3) v3_q <= valid_i;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && valid_i) begin
      pa_q  <= pa_d;
      pb_q  <= pb_d;
      fs3_q <= fs_d;
    end
    if (rdy4 && v3_q) begin
      c_q   <= c_d;
      fs4_q <= fs3_q;
    end
  end

  assign valid_o = v4_q;
  assign cross_o = c_q;
  assign fsum_o  = fs4_q;

endmodule

@@ rtl/ftgc_output.sv @@
// torque sum, saturation of both wrench halves and the output register
// depends on ftgc_pkg
module ftgc_output import ftgc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  vecc_t  cross_i,
  input  vecf_t  fsum_i,
  input  vec18_t tbias_i,
  output logic   valid_o,
  input  logic   ready_i,
  output logic [2:0][OutW-1:0] force_o,
  output logic [2:0][OutW-1:0] torque_o
);

  logic [2:0][OutW-1:0] force_d, force_q, torque_d, torque_q;
  logic v5_q;
  logic rdy5;

  assign rdy5    = !v5_q || ready_i;
  assign ready_o = rdy5;

  // negate the torque sum, then clamp both halves
  always_comb begin
    logic signed [TsumW-1:0] tsum;
    logic signed [TsumW-1:0] fsx;
    for (int i = 0; i < 3; i++) begin
      tsum        = -($signed(tbias_i[i]) + $signed(cross_i[i]));
      fsx         = $signed(fsum_i[i]);
      torque_d[i] = sat_out(tsum);
      force_d[i]  = sat_out(fsx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (rdy5) begin
      v5_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy5 && valid_i) begin
      force_q  <= force_d;
      torque_q <= torque_d;
    end
  end

  assign valid_o  = v5_q;
  assign force_o  = force_q;
  assign torque_o = torque_q;

endmodule

@@ rtl/ft_gravity_compensation_core.sv @@
// force/torque gravity compensation: five register stages, one transaction per cycle.
// an accepted input passes the rotate, cross and output stage registers before output valid;
// throughput one item per cycle unless the output stalls, set by the fully pipelined multipliers.
// an output stall backs up stage by stage; bubbles still fill while the result waits.
// async active-low reset clears all valid bits and the four config registers to zero.
module ft_gravity_compensation_core import ftgc_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [RotW-1:0]    rot_r0c0_i,
  input  logic signed [RotW-1:0]    rot_r0c1_i,
  input  logic signed [RotW-1:0]    rot_r0c2_i,
  input  logic signed [RotW-1:0]    rot_r1c0_i,
  input  logic signed [RotW-1:0]    rot_r1c1_i,
  input  logic signed [RotW-1:0]    rot_r1c2_i,
  input  logic signed [RotW-1:0]    rot_r2c0_i,
  input  logic signed [RotW-1:0]    rot_r2c1_i,
  input  logic signed [RotW-1:0]    rot_r2c2_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [OutW-1:0]    comp_force_x_o,
  output logic signed [OutW-1:0]    comp_force_y_o,
  output logic signed [OutW-1:0]    comp_force_z_o,
  output logic signed [OutW-1:0]    comp_torque_x_o,
  output logic signed [OutW-1:0]    comp_torque_y_o,
  output logic signed [OutW-1:0]    comp_torque_z_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [CfgW-1:0]           cfg_data_i
);

  vec18_t grav_q, fbias_q, mass_q, tbias_q;
  mat_t   rot;
  vecg_t  grav_s;
  vecc_t  cross_w;
  vecf_t  fsum;
  logic   rot_valid, rot_ready, crs_valid, crs_ready;
  logic [2:0][OutW-1:0] force_w, torque_w;

  // configuration registers, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q  <= '0;
      fbias_q <= '0;
      mass_q  <= '0;
      tbias_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_GRAVITY:     grav_q  <= cfg_data_i;
        REG_FORCE_BIAS:  fbias_q <= cfg_data_i;
        REG_MASS_CENTER: mass_q  <= cfg_data_i;
        REG_TORQUE_BIAS: tbias_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // matrix entry order is row * 3 + column
  assign rot = {rot_r2c2_i, rot_r2c1_i, rot_r2c0_i,
                rot_r1c2_i, rot_r1c1_i, rot_r1c0_i,
                rot_r0c2_i, rot_r0c1_i, rot_r0c0_i};

  ftgc_rotate u_rotate (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .ready_o  (in_ready_o),
    .rot_i    (rot),
    .grav_i   (grav_q),
    .valid_o  (rot_valid),
    .ready_i  (rot_ready),
    .grav_s_o (grav_s)
  );

  ftgc_cross u_cross (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (rot_valid),
    .ready_o  (rot_ready),
    .grav_s_i (grav_s),
    .mass_i   (mass_q),
    .fbias_i  (fbias_q),
    .valid_o  (crs_valid),
    .ready_i  (crs_ready),
    .cross_o  (cross_w),
    .fsum_o   (fsum)
  );

  ftgc_output u_output (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (crs_valid),
    .ready_o  (crs_ready),
    .cross_i  (cross_w),
    .fsum_i   (fsum),
    .tbias_i  (tbias_q),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .force_o  (force_w),
    .torque_o (torque_w)
  );

  assign comp_force_x_o  = force_w[0];
  assign comp_force_y_o  = force_w[1];
  assign comp_force_z_o  = force_w[2];
  assign comp_torque_x_o = torque_w[0];
  assign comp_torque_y_o = torque_w[1];
  assign comp_torque_z_o = torque_w[2];

endmodule

@@ rtl/ftgc_checker.sv @@
// port-level checks for the gravity compensation core, bound to the top level
// depends on ft_gravity_compensation_core_defines.svh and ftgc_pkg
`include "ft_gravity_compensation_core_defines.svh"

module ftgc_checker import ftgc_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic signed [RotW-1:0] rot_r0c0_i,
  input logic signed [RotW-1:0] rot_r0c1_i,
  input logic signed [RotW-1:0] rot_r0c2_i,
  input logic signed [RotW-1:0] rot_r1c0_i,
  input logic signed [RotW-1:0] rot_r1c1_i,
  input logic signed [RotW-1:0] rot_r1c2_i,
  input logic signed [RotW-1:0] rot_r2c0_i,
  input logic signed [RotW-1:0] rot_r2c1_i,
  input logic signed [RotW-1:0] rot_r2c2_i,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic signed [OutW-1:0] comp_force_x_o,
  input logic signed [OutW-1:0] comp_force_y_o,
  input logic signed [OutW-1:0] comp_force_z_o,
  input logic signed [OutW-1:0] comp_torque_x_o,
  input logic signed [OutW-1:0] comp_torque_y_o,
  input logic signed [OutW-1:0] comp_torque_z_o,
  input logic                   cfg_valid_i,
  input logic                   cfg_ready_o,
  input logic [CfgIdxW-1:0]     cfg_index_i,
  input logic [CfgW-1:0]        cfg_data_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o && rst_ni;

  // a stalled result stays valid and holds its force x and torque z values
  `FTGC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(comp_force_x_o) && $stable(comp_torque_z_o))

  // the input side only stalls when a result is waiting
  `FTGC_ASSERT_IMPL(a_stall_needs_result, !in_ready_o, out_valid_o)

  // a transaction accepted while the output side stays ready shows up as out_valid_o
  `FTGC_ASSERT_IMPL(a_latency, $past(in_acc, 5) && $past(out_ready_i, 4) &&
    $past(out_ready_i, 3) && $past(out_ready_i, 2) && $past(out_ready_i, 1), out_valid_o)

  // config writes never stall
  `FTGC_ASSERT_IMPL(a_cfg_ready, cfg_valid_i, cfg_ready_o)

endmodule

bind ft_gravity_compensation_core ftgc_checker u_ftgc_checker (.*);
